/* rtl/core/settle_then_average_tracker_unit_macros.svh */
// Assertion macros used by the tracker datapath
`ifndef SETTLE_THEN_AVERAGE_TRACKER_UNIT_MACROS_SVH
`define SETTLE_THEN_AVERAGE_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define STAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define STAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/stat_pkg.sv */
// Shared types, constants and helpers of the settle-then-average tracker
`default_nettype none
package stat_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int THR_W    = 15;
    localparam int STS_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int STEP_W   = $clog2(SAMPLE_W);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] SETTLE_COUNT_RST     = CNT_W'(10);
    localparam logic [THR_W-1:0] SETTLE_THRESHOLD_RST = THR_W'(30);
    localparam logic [THR_W-1:0] TRACK_THRESHOLD_RST  = THR_W'(25);

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_THRESHOLD  = 2'd2;

    typedef enum logic [STS_W-1:0] {
        ST_SETTLING = 3'd0,
        ST_SETTLED  = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_DEVIATED = 3'd3,
        ST_IDLE     = 3'd4,
        ST_LIMIT    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_TRACK  = 4'b0100,
        PH_HOLD   = 4'b1000
    } t_phase;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b000_0001,
        S_EVAL      = 7'b000_0010,
        S_DIVH_GO   = 7'b000_0100,
        S_DIVH_WAIT = 7'b000_1000,
        S_DIVP_GO   = 7'b001_0000,
        S_DIVP_WAIT = 7'b010_0000,
        S_EMIT      = 7'b100_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_go;
        logic div_sel;  // 0 heading, 1 pressure
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic upd;
        logic div_done;
        logic out_free;
    } t_sts;

    // wrapped signed difference a - b, magnitude above thr
    function automatic logic out_of_band(input logic [SAMPLE_W-1:0] a,
                                         input logic [SAMPLE_W-1:0] b,
                                         input logic [THR_W-1:0] thr);
        logic [SAMPLE_W-1:0] d;
        logic [SAMPLE_W-1:0] mag;
        d   = a - b;
        mag = d[SAMPLE_W-1] ? (~d + SAMPLE_W'(1)) : d;
        return mag > SAMPLE_W'(thr);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/settle_then_average_tracker_unit.sv */
// A sample that updates no mean is evaluated and written to the result register;
// one that updates the means first takes two 16-step passes of the shared divider.
// Samples are taken one at a time; the single iterative divider paces the stream.
// A new sample is taken while the previous result still waits in the output register.
// Reset: synchronous, active low; registers return to defaults (10, 30, 25),
// tracking restarts waiting for the first sample, means and sums clear to zero.
`default_nettype none
module settle_then_average_tracker_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [stat_pkg::SAMPLE_W-1:0]     i_heading,
    input  wire logic [stat_pkg::SAMPLE_W-1:0]     i_pressure,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [stat_pkg::STS_W-1:0]             o_status,
    output logic [stat_pkg::SAMPLE_W-1:0]          o_mean_heading,
    output logic [stat_pkg::SAMPLE_W-1:0]          o_mean_pressure,
    output logic [stat_pkg::CNT_W-1:0]             o_stable_run,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [stat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stat_pkg::CFG_DAT_W-1:0]    i_cfg_wr_data
);

    stat_pkg::t_cmd cmd;
    stat_pkg::t_sts sts;

    stat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    stat_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_heading       (i_heading),
        .i_pressure      (i_pressure),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (cmd),
        .i_ready         (i_ready),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_mean_heading  (o_mean_heading),
        .o_mean_pressure (o_mean_pressure),
        .o_stable_run    (o_stable_run)
    );

endmodule
`default_nettype wire

/* rtl/core/stat_div.sv */
// Iterative restoring divider, one quotient bit per cycle
`default_nettype none
module stat_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic [stat_pkg::SUM_W-1:0]    i_dividend,
    input  wire logic [stat_pkg::CNT_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [stat_pkg::SAMPLE_W-1:0]      o_quotient
);

    logic [stat_pkg::CNT_W-1:0]    r_rem;
    logic [stat_pkg::SAMPLE_W-1:0] r_low;
    logic [stat_pkg::CNT_W-1:0]    r_dvs;
    logic [stat_pkg::STEP_W-1:0]   r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [stat_pkg::CNT_W:0] trial;
    logic [stat_pkg::CNT_W:0] diff;

    always_comb begin
        trial = {r_rem, r_low[stat_pkg::SAMPLE_W-1]};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + stat_pkg::STEP_W'(1);
                if (r_cnt == stat_pkg::STEP_W'(stat_pkg::SAMPLE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient fits SAMPLE_W bits: the top part of the dividend is below the divisor
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_dividend[stat_pkg::SUM_W-1:stat_pkg::SAMPLE_W];
            r_low <= i_dividend[stat_pkg::SAMPLE_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[stat_pkg::CNT_W]) begin
                r_rem <= diff[stat_pkg::CNT_W-1:0];
                r_low <= {r_low[stat_pkg::SAMPLE_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[stat_pkg::CNT_W-1:0];
                r_low <= {r_low[stat_pkg::SAMPLE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

endmodule
`default_nettype wire

/* rtl/core/stat_dp.sv */
// Tracker datapath: config, settle and track state, sums, means, result register
`default_nettype none
`include "settle_then_average_tracker_unit_macros.svh"
module stat_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [stat_pkg::SAMPLE_W-1:0]     i_heading,
    input  wire logic [stat_pkg::SAMPLE_W-1:0]     i_pressure,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [stat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [stat_pkg::CFG_DAT_W-1:0]    i_cfg_wr_data,
    input  wire stat_pkg::t_cmd                    i_cmd,
    input  wire logic                              i_ready,
    output stat_pkg::t_sts                         o_sts,
    output logic                                   o_valid,
    output logic [stat_pkg::STS_W-1:0]             o_status,
    output logic [stat_pkg::SAMPLE_W-1:0]          o_mean_heading,
    output logic [stat_pkg::SAMPLE_W-1:0]          o_mean_pressure,
    output logic [stat_pkg::CNT_W-1:0]             o_stable_run
);

    logic [stat_pkg::CNT_W-1:0]    r_cfg_cnt;
    logic [stat_pkg::THR_W-1:0]    r_cfg_sthr;
    logic [stat_pkg::THR_W-1:0]    r_cfg_tthr;

    logic [stat_pkg::SAMPLE_W-1:0] r_h;
    logic [stat_pkg::SAMPLE_W-1:0] r_p;

    stat_pkg::t_phase              r_phase, n_phase;
    logic [stat_pkg::SAMPLE_W-1:0] r_base, n_base;
    logic [stat_pkg::CNT_W-1:0]    r_run, n_run;
    logic [stat_pkg::CNT_W-1:0]    r_total, n_total;
    logic [stat_pkg::SUM_W-1:0]    r_hsum, n_hsum;
    logic [stat_pkg::SUM_W-1:0]    r_psum, n_psum;
    logic [stat_pkg::SAMPLE_W-1:0] r_hmean, n_hmean;
    logic [stat_pkg::SAMPLE_W-1:0] r_pmean, n_pmean;
    stat_pkg::t_status             r_status, n_status;

    logic                          r_sel;
    logic                          r_ov;
    logic [stat_pkg::STS_W-1:0]    r_o_status;
    logic [stat_pkg::SAMPLE_W-1:0] r_o_mh;
    logic [stat_pkg::SAMPLE_W-1:0] r_o_mp;
    logic [stat_pkg::CNT_W-1:0]    r_o_run;

    logic                          oob_settle;
    logic                          oob_track;
    logic [stat_pkg::CNT_W-1:0]    run_step;
    logic                          at_limit;
    logic                          upd;

    logic                          div_done;
    logic [stat_pkg::SAMPLE_W-1:0] div_q;
    logic [stat_pkg::SUM_W-1:0]    div_dvd;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt  <= stat_pkg::SETTLE_COUNT_RST;
            r_cfg_sthr <= stat_pkg::SETTLE_THRESHOLD_RST;
            r_cfg_tthr <= stat_pkg::TRACK_THRESHOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                stat_pkg::REG_SETTLE_COUNT: begin
                    r_cfg_cnt <= i_cfg_wr_data[stat_pkg::CNT_W-1:0];
                end
                stat_pkg::REG_SETTLE_THRESHOLD: begin
                    r_cfg_sthr <= i_cfg_wr_data[stat_pkg::THR_W-1:0];
                end
                stat_pkg::REG_TRACK_THRESHOLD: begin
                    r_cfg_tthr <= i_cfg_wr_data[stat_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sample latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_h <= i_heading;
            r_p <= i_pressure;
        end
    end

    always_comb begin
        oob_settle = stat_pkg::out_of_band(r_base, r_h, r_cfg_sthr);
        oob_track  = stat_pkg::out_of_band(r_hmean, r_h, r_cfg_tthr);
        if (oob_settle) begin
            run_step = '0;
        end else if (r_run != stat_pkg::CNT_MAX) begin
            run_step = r_run + stat_pkg::CNT_W'(1);
        end else begin
            run_step = r_run;
        end
        at_limit = (r_total == stat_pkg::CNT_MAX);
        upd      = (r_phase == stat_pkg::PH_TRACK) && !at_limit && !oob_track;
    end

    always_comb begin
        n_phase  = r_phase;
        n_base   = r_base;
        n_run    = r_run;
        n_total  = r_total;
        n_hsum   = r_hsum;
        n_psum   = r_psum;
        n_hmean  = r_hmean;
        n_pmean  = r_pmean;
        n_status = r_status;
        if (i_cmd.eval) begin
            case (r_phase)
                stat_pkg::PH_FIRST: begin
                    n_base   = r_h;
                    n_run    = '0;
                    n_phase  = stat_pkg::PH_SETTLE;
                    n_status = stat_pkg::ST_SETTLING;
                end
                stat_pkg::PH_SETTLE: begin
                    n_run = run_step;
                    if (oob_settle) begin
                        n_base = r_h;
                    end
                    if (run_step >= r_cfg_cnt) begin
                        n_hmean  = r_h;
                        n_pmean  = r_p;
                        n_hsum   = stat_pkg::SUM_W'(r_h);
                        n_psum   = stat_pkg::SUM_W'(r_p);
                        n_total  = stat_pkg::CNT_W'(1);
                        n_phase  = stat_pkg::PH_TRACK;
                        n_status = stat_pkg::ST_SETTLED;
                    end else begin
                        n_status = stat_pkg::ST_SETTLING;
                    end
                end
                stat_pkg::PH_TRACK: begin
                    if (at_limit) begin
                        n_phase  = stat_pkg::PH_HOLD;
                        n_status = stat_pkg::ST_LIMIT;
                    end else begin
                        n_total = r_total + stat_pkg::CNT_W'(1);
                        if (oob_track) begin
                            n_phase  = stat_pkg::PH_HOLD;
                            n_status = stat_pkg::ST_DEVIATED;
                        end else begin
                            n_hsum   = r_hsum + stat_pkg::SUM_W'(r_h);
                            n_psum   = r_psum + stat_pkg::SUM_W'(r_p);
                            n_status = stat_pkg::ST_UPDATED;
                        end
                    end
                end
                default: begin
                    n_status = stat_pkg::ST_IDLE;
                end
            endcase
        end
        // means land from the divider
        if (div_done) begin
            if (r_sel) begin
                n_pmean = div_q;
            end else begin
                n_hmean = div_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= stat_pkg::PH_FIRST;
            r_base   <= '0;
            r_run    <= '0;
            r_total  <= '0;
            r_hsum   <= '0;
            r_psum   <= '0;
            r_hmean  <= '0;
            r_pmean  <= '0;
            r_status <= stat_pkg::ST_SETTLING;
            r_sel    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_base   <= n_base;
            r_run    <= n_run;
            r_total  <= n_total;
            r_hsum   <= n_hsum;
            r_psum   <= n_psum;
            r_hmean  <= n_hmean;
            r_pmean  <= n_pmean;
            r_status <= n_status;
            if (i_cmd.div_go) begin
                r_sel <= i_cmd.div_sel;
            end
        end
    end

    assign div_dvd = i_cmd.div_sel ? r_psum : r_hsum;

    stat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (div_dvd),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // result register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_mh     <= r_hmean;
            r_o_mp     <= r_pmean;
            r_o_run    <= r_run;
        end
    end

    always_comb begin
        o_sts.upd      = upd;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_ov || i_ready;
    end

    assign o_valid         = r_ov;
    assign o_status        = r_o_status;
    assign o_mean_heading  = r_o_mh;
    assign o_mean_pressure = r_o_mp;
    assign o_stable_run    = r_o_run;

    `STAT_ASSERT_NOW(a_hsum_bound, r_phase == stat_pkg::PH_TRACK,
        r_hsum[stat_pkg::SUM_W-1:stat_pkg::SAMPLE_W] < r_total, "heading sum too large")
    `STAT_ASSERT_NOW(a_psum_bound, r_phase == stat_pkg::PH_TRACK,
        r_psum[stat_pkg::SUM_W-1:stat_pkg::SAMPLE_W] < r_total, "pressure sum too large")
    `STAT_ASSERT_NOW(a_first_clear, r_phase == stat_pkg::PH_FIRST,
        r_run == '0 && r_total == '0, "state dirty before first sample")
    `STAT_ASSERT_NOW(a_emit_slot, i_cmd.emit, !r_ov || i_ready, "result overwritten")

endmodule
`default_nettype wire

/* rtl/core/stat_ctrl.sv */
// Tracker controller: sequences evaluation, the two divisions and the result hand-off
`default_nettype none
module stat_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire stat_pkg::t_sts i_sts,
    output logic                o_ready,
    output stat_pkg::t_cmd      o_cmd
);

    stat_pkg::t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.eval    = 1'b0;
        o_cmd.div_go  = 1'b0;
        o_cmd.div_sel = 1'b0;
        o_cmd.emit    = 1'b0;
        case (r_state)
            stat_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = stat_pkg::S_EVAL;
                end
            end
            stat_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.upd ? stat_pkg::S_DIVH_GO : stat_pkg::S_EMIT;
            end
            stat_pkg::S_DIVH_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = stat_pkg::S_DIVH_WAIT;
            end
            stat_pkg::S_DIVH_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = stat_pkg::S_DIVP_GO;
                end
            end
            stat_pkg::S_DIVP_GO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = 1'b1;
                n_state       = stat_pkg::S_DIVP_WAIT;
            end
            stat_pkg::S_DIVP_WAIT: begin
                o_cmd.div_sel = 1'b1;
                if (i_sts.div_done) begin
                    n_state = stat_pkg::S_EMIT;
                end
            end
            stat_pkg::S_EMIT: begin
                // wait for the result register to free up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = stat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* test/settle_then_average_tracker_unit_tb.sv */
// Self-checking testbench of the settle-then-average tracker: directed table, then random runs
`default_nettype none
module settle_then_average_tracker_unit_tb;
    import stat_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [SAMPLE_W-1:0] mh;
        logic [SAMPLE_W-1:0] mp;
        logic [CNT_W-1:0]    run;
    } tracker_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    // a write row uses idx and data, a sample row hd and pr; typed rows carry their result
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DAT_W-1:0]   data;
        logic [SAMPLE_W-1:0]    hd;
        logic [SAMPLE_W-1:0]    pr;
        logic                   typed;
        t_status                st;
        logic [CNT_W-1:0]       run;
    } stim_row_t;

    localparam int N_ROWS = 17;

    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h0000, 16'h0000, 1'b1, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, ST_SETTLING, 16'd1},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h001E, 16'h1234, 1'b1, ST_SETTLING, 16'd2},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h001F, 16'h0000, 1'b1, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h003D, 16'hABCD, 1'b1, ST_SETTLING, 16'd1},
        '{ROW_WRITE, REG_SETTLE_THRESHOLD, 16'h0000, 16'h0, 16'h0, 1'b0, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h001F, 16'h5555, 1'b1, ST_SETTLING, 16'd2},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h0020, 16'hAAAA, 1'b1, ST_SETTLING, 16'd0},
        '{ROW_WRITE, REG_SETTLE_THRESHOLD, 16'h7FFF, 16'h0, 16'h0, 1'b0, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h801F, 16'h0001, 1'b1, ST_SETTLING, 16'd1},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h8020, 16'hFFFE, 1'b1, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h0021, 16'h7FFF, 1'b1, ST_SETTLING, 16'd1},
        '{ROW_WRITE, REG_SETTLE_COUNT, 16'hFFFF, 16'h0, 16'h0, 1'b0, ST_SETTLING, 16'd0},
        '{ROW_WRITE, REG_TRACK_THRESHOLD, 16'h7FFF, 16'h0, 16'h0, 1'b0, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'hFFFF, 16'h8000, 1'b0, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h7FFF, 16'h7FFF, 1'b0, ST_SETTLING, 16'd0},
        '{ROW_SAMPLE, REG_SETTLE_COUNT, 16'd0, 16'h8000, 16'h0000, 1'b0, ST_SETTLING, 16'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [SAMPLE_W-1:0]  i_heading;
    logic [SAMPLE_W-1:0]  i_pressure;
    logic                 o_valid;
    logic                 i_ready;
    logic [STS_W-1:0]     o_status;
    logic [SAMPLE_W-1:0]  o_mean_heading;
    logic [SAMPLE_W-1:0]  o_mean_pressure;
    logic [CNT_W-1:0]     o_stable_run;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wr_data;

    // tracker state as predicted, with its register copies
    t_phase              trk_phase = PH_FIRST;
    logic [SAMPLE_W-1:0] trk_base  = '0;
    logic [CNT_W-1:0]    trk_run   = '0;
    logic [CNT_W-1:0]    trk_total = '0;
    logic [SUM_W-1:0]    trk_hsum  = '0;
    logic [SUM_W-1:0]    trk_psum  = '0;
    logic [SAMPLE_W-1:0] trk_hmean = '0;
    logic [SAMPLE_W-1:0] trk_pmean = '0;
    logic [CNT_W-1:0]    cfg_settle_cnt = SETTLE_COUNT_RST;
    logic [THR_W-1:0]    cfg_settle_thr = SETTLE_THRESHOLD_RST;
    logic [THR_W-1:0]    cfg_track_thr  = TRACK_THRESHOLD_RST;

    tracker_result_t pending_results [$];
    tracker_result_t typed_result;
    tracker_result_t fresh;
    tracker_result_t want;
    logic            use_typed = 1'b0;
    logic            steady = 1'b0;
    int              mismatches = 0;

    settle_then_average_tracker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_heading       (i_heading),
        .i_pressure      (i_pressure),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_mean_heading  (o_mean_heading),
        .o_mean_pressure (o_mean_pressure),
        .o_stable_run    (o_stable_run),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    // wrapped signed difference anchor - hd, magnitude compared with thr
    function automatic logic beyond_band(input logic [SAMPLE_W-1:0] anchor,
                                         input logic [SAMPLE_W-1:0] hd,
                                         input logic [THR_W-1:0] thr);
        logic [SAMPLE_W-1:0] d;
        int                  dv;
        d  = anchor - hd;
        dv = int'($signed(d));
        if (dv < 0) dv = -dv;
        return dv > int'(thr);
    endfunction

    function automatic tracker_result_t advance_tracker(input logic [SAMPLE_W-1:0] hd,
                                                        input logic [SAMPLE_W-1:0] pr);
        tracker_result_t r;
        r.status = ST_SETTLING;
        case (trk_phase)
            PH_FIRST: begin
                trk_base  = hd;
                trk_run   = '0;
                trk_phase = PH_SETTLE;
            end
            PH_SETTLE: begin
                if (beyond_band(trk_base, hd, cfg_settle_thr)) begin
                    trk_run  = '0;
                    trk_base = hd;
                end else if (trk_run != CNT_MAX) begin
                    trk_run = trk_run + CNT_W'(1);
                end
                if (trk_run >= cfg_settle_cnt) begin
                    trk_hmean = hd;
                    trk_pmean = pr;
                    trk_hsum  = SUM_W'(hd);
                    trk_psum  = SUM_W'(pr);
                    trk_total = CNT_W'(1);
                    trk_phase = PH_TRACK;
                    r.status  = ST_SETTLED;
                end
            end
            PH_TRACK: begin
                if (trk_total == CNT_MAX) begin
                    trk_phase = PH_HOLD;
                    r.status  = ST_LIMIT;
                end else begin
                    trk_total = trk_total + CNT_W'(1);
                    if (beyond_band(trk_hmean, hd, cfg_track_thr)) begin
                        trk_phase = PH_HOLD;
                        r.status  = ST_DEVIATED;
                    end else begin
                        trk_hsum  = trk_hsum + SUM_W'(hd);
                        trk_psum  = trk_psum + SUM_W'(pr);
                        trk_hmean = SAMPLE_W'(trk_hsum / SUM_W'(trk_total));
                        trk_pmean = SAMPLE_W'(trk_psum / SUM_W'(trk_total));
                        r.status  = ST_UPDATED;
                    end
                end
            end
            default: r.status = ST_IDLE;
        endcase
        r.mh  = trk_hmean;
        r.mp  = trk_pmean;
        r.run = trk_run;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t mismatch on %s: got %0h, wanted %0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    // predict on every input transaction, check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_SETTLE_COUNT:     cfg_settle_cnt = i_cfg_wr_data;
                    REG_SETTLE_THRESHOLD: cfg_settle_thr = i_cfg_wr_data[THR_W-1:0];
                    REG_TRACK_THRESHOLD:  cfg_track_thr  = i_cfg_wr_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                fresh = advance_tracker(i_heading, i_pressure);
                pending_results.push_back(use_typed ? typed_result : fresh);
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(o_status), 32'(0));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_mean_heading !== want.mh)
                        report_mismatch("mean_heading", 32'(o_mean_heading), 32'(want.mh));
                    if (o_mean_pressure !== want.mp)
                        report_mismatch("mean_pressure", 32'(o_mean_pressure), 32'(want.mp));
                    if (o_stable_run !== want.run)
                        report_mismatch("stable_run", 32'(o_stable_run), 32'(want.run));
                end
            end
        end
    end

    // receiver: stall at random except in a steady stretch
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= steady || ($urandom_range(99) >= 29);
    end

    // starts and ends at a falling edge; holds the payload until the transaction
    task automatic send_sample(input logic [SAMPLE_W-1:0] hd, input logic [SAMPLE_W-1:0] pr);
        while (!steady && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_heading  <= hd;
        i_pressure <= pr;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // drain the block first so that no sample is in flight during the write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int                  thr;
        int                  off;
        int unsigned         pick;
        logic [SAMPLE_W-1:0] hd;
        logic [SAMPLE_W-1:0] pr;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_heading     = '0;
        i_pressure    = '0;
        i_ready       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wr_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_ROWS; k++) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                write_reg(directed_rows[k].idx, directed_rows[k].data);
            end else begin
                use_typed    = directed_rows[k].typed;
                typed_result = '{directed_rows[k].st, '0, '0, directed_rows[k].run};
                send_sample(directed_rows[k].hd, directed_rows[k].pr);
            end
        end
        use_typed = 1'b0;

        // settling noise: with the count at its top the run never completes
        for (int s = 0; s < 3; s++) begin
            pick = (s == 0) ? 40 : ((s == 1) ? 2000 : 32767);
            write_reg(REG_SETTLE_THRESHOLD, CFG_DAT_W'($urandom_range(pick)));
            repeat (150) begin
                thr = int'(cfg_settle_thr);
                if ($urandom_range(99) < 75)
                    hd = trk_base + SAMPLE_W'(int'($urandom_range(2 * thr)) - thr);
                else
                    hd = SAMPLE_W'($urandom);
                send_sample(hd, SAMPLE_W'($urandom));
            end
        end

        // a mostly in-band run that reaches the settle count
        pick = $urandom_range(3);
        write_reg(REG_SETTLE_THRESHOLD, CFG_DAT_W'($urandom_range(60)));
        write_reg(REG_SETTLE_COUNT, (pick == 0) ? CFG_DAT_W'(0) :
                  ((pick == 1) ? CFG_DAT_W'(1) : CFG_DAT_W'($urandom_range(2, 24))));
        while (trk_phase != PH_TRACK) begin
            thr = int'(cfg_settle_thr);
            if ($urandom_range(99) < 90)
                hd = trk_base + SAMPLE_W'(int'($urandom_range(2 * thr)) - thr);
            else
                hd = SAMPLE_W'($urandom);
            send_sample(hd, SAMPLE_W'($urandom));
        end

        // tracking: keep every heading within band of the current mean
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: pick = $urandom_range(1, 200);
                1: pick = 0;
                2: pick = 32767;
                3: pick = $urandom_range(32767);
                default: pick = $urandom_range(1, 3000);
            endcase
            write_reg(REG_TRACK_THRESHOLD, CFG_DAT_W'(pick));
            steady = (s == 2);
            repeat (300) begin
                thr = int'(cfg_track_thr);
                hd  = trk_hmean + SAMPLE_W'(int'($urandom_range(2 * thr)) - thr);
                pr  = SAMPLE_W'($urandom);
                if ($urandom_range(9) == 0) pr = {SAMPLE_W{pr[0]}};
                send_sample(hd, pr);
            end
        end
        steady = 1'b0;

        // step just outside the band to end tracking
        off = int'(cfg_track_thr) + 1;
        if ($urandom_range(1) == 1) off = -off;
        send_sample(trk_hmean + SAMPLE_W'(off), SAMPLE_W'($urandom));

        write_reg(REG_SETTLE_COUNT, CFG_DAT_W'($urandom_range(1, 65535)));
        repeat (20) send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
